[hw/rtl/tcu_pkg.sv]
package tcu_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegHighThr   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegLowThr    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPasses    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSeqTmo    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLockout   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegDebounce  = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [15:0] HighThrRst  = 16'd27853;
  localparam logic [15:0] LowThrRst   = 16'd26870;
  localparam logic [3:0]  PassesRst   = 4'd3;
  localparam logic [31:0] SeqTmoRst   = 32'd10000;
  localparam logic [31:0] LockoutRst  = 32'd5000;
  localparam logic [31:0] DebounceRst = 32'd100;

  // Item modes.
  localparam logic [1:0] ModeSample = 2'd0;
  localparam logic [1:0] ModeUnlock = 2'd1;
  localparam logic [1:0] ModeLock   = 2'd2;
  localparam logic [1:0] ModeReset  = 2'd3;

  // Result events.
  localparam logic [2:0] EvNone    = 3'd0;
  localparam logic [2:0] EvRise    = 3'd1;
  localparam logic [2:0] EvFall    = 3'd2;
  localparam logic [2:0] EvUnlock  = 3'd3;
  localparam logic [2:0] EvTimeout = 3'd4;
  localparam logic [2:0] EvLockEnd = 3'd5;

  typedef struct packed {
    logic [15:0] high_thr;
    logic [15:0] low_thr;
    logic [3:0]  passes;
    logic [31:0] seq_tmo_ms;
    logic [31:0] lockout_ms;
    logic [31:0] debounce_ms;
  } cfg_t;

endpackage

[hw/rtl/tcu_cfg.sv]
module tcu_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tcu_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tcu_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output tcu_pkg::cfg_t                 cfg_o
);

  tcu_pkg::cfg_t cfg_q;

  // Writes keep only the low bits of each register; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.high_thr    <= tcu_pkg::HighThrRst;
      cfg_q.low_thr     <= tcu_pkg::LowThrRst;
      cfg_q.passes      <= tcu_pkg::PassesRst;
      cfg_q.seq_tmo_ms  <= tcu_pkg::SeqTmoRst;
      cfg_q.lockout_ms  <= tcu_pkg::LockoutRst;
      cfg_q.debounce_ms <= tcu_pkg::DebounceRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tcu_pkg::RegHighThr:  cfg_q.high_thr    <= cfg_wdata_i[15:0];
        tcu_pkg::RegLowThr:   cfg_q.low_thr     <= cfg_wdata_i[15:0];
        tcu_pkg::RegPasses:   cfg_q.passes      <= cfg_wdata_i[3:0];
        tcu_pkg::RegSeqTmo:   cfg_q.seq_tmo_ms  <= cfg_wdata_i[31:0];
        tcu_pkg::RegLockout:  cfg_q.lockout_ms  <= cfg_wdata_i[31:0];
        tcu_pkg::RegDebounce: cfg_q.debounce_ms <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hw/rtl/threshold_crossing_unlock_fsm.sv]
// Threshold crossing unlock machine. Every input beat gives exactly one result
// beat. A beat carries a mode (sample, force unlock, force lock, reset), a
// Q1.15 sample and a millisecond timestamp. Samples drive a seven-state
// machine: idle arms below the low threshold, armed and the crossing states
// count debounced rising crossings of the high threshold, the third crossing
// leads to unlock when the count meets the required pass count, an active
// sequence times out back to idle, and an unlocked machine drops to lockout
// when the sample falls 0.1 (3277 in Q1.15) below the low threshold; lockout
// ends lockout_ms after the unlock time. All time differences wrap modulo 2^32.
// Timing: a beat is taken into an input register, and once the result register
// is empty or being emptied one pass of compare and subtract logic updates the
// machine and fills the result register. One beat is accepted every cycle
// while the result side keeps taking beats. The configuration registers must
// only be written while no beat is in flight.
module threshold_crossing_unlock_fsm (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [tcu_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tcu_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // Input channel.
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    mode_i,
  input  logic [15:0]                   sample_value_i,
  input  logic [31:0]                   now_ms_i,
  // Result channel.
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    event_res_o,
  output logic [2:0]                    machine_state_o,
  output logic [3:0]                    crossing_total_o,
  output logic                          unlock_granted_o,
  output logic [31:0]                   state_duration_ms_o,
  output logic [31:0]                   unlock_duration_ms_o
);

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_ARMED    = 3'd1,
    ST_CROSS1   = 3'd2,
    ST_CROSS2   = 3'd3,
    ST_CROSS3   = 3'd4,
    ST_UNLOCKED = 3'd5,
    ST_LOCKED   = 3'd6
  } state_e;

  // The 0.1 lockout margin in Q1.15.
  localparam logic [16:0] MarginQ15 = 17'd3277;

  tcu_pkg::cfg_t cfg;

  tcu_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Input register.
  logic        in_valid_q;
  logic [1:0]  mode_q;
  logic [15:0] sample_q;
  logic [31:0] now_q;

  // Machine state.
  state_e      state_q, state_d;
  logic [15:0] prev_sample_q, prev_sample_d;
  logic [31:0] last_edge_q, last_edge_d;
  logic [31:0] seq_start_q, seq_start_d;
  logic [31:0] unlock_time_q, unlock_time_d;
  logic [3:0]  count_q, count_d;
  logic        unlocked_q, unlocked_d;

  // Result register.
  logic        out_valid_q;
  logic [2:0]  event_q, event_d;
  logic [31:0] dur_q, dur_d;
  logic [31:0] unlock_dur_q, unlock_dur_d;

  logic in_accept;
  logic advance;

  // The pass fires when an item sits in the input register and the result
  // register is empty or being emptied in this cycle.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_accept  = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mode_q   <= mode_i;
      sample_q <= sample_value_i;
      now_q    <= now_ms_i;
    end
  end

  // Shared terms of the step.
  logic [31:0] dur_pre;
  logic [31:0] since_edge;
  logic [31:0] since_unlock;
  logic        deb_ok;
  logic        seq_active;
  logic        timed_out;
  logic        lock_over;
  logic        below_low;
  logic        rise_lvl;
  logic        fall_lvl;
  logic        fall_hit;
  logic        rise_hit;
  logic        below_margin;

  assign dur_pre      = now_q - seq_start_q;
  assign since_edge   = now_q - last_edge_q;
  assign since_unlock = now_q - unlock_time_q;
  assign deb_ok       = since_edge >= cfg.debounce_ms;
  assign seq_active   = (state_q == ST_ARMED) || (state_q == ST_CROSS1) ||
                        (state_q == ST_CROSS2) || (state_q == ST_CROSS3);
  assign timed_out    = seq_active && (dur_pre > cfg.seq_tmo_ms);
  assign lock_over    = since_unlock > cfg.lockout_ms;
  assign below_low    = sample_q < cfg.low_thr;
  assign rise_lvl     = (prev_sample_q < cfg.high_thr) && (sample_q >= cfg.high_thr);
  assign fall_lvl     = (prev_sample_q >= cfg.low_thr) && below_low;
  assign fall_hit     = deb_ok && fall_lvl;
  // A falling edge in the same sample takes the debounce slot, so a rising
  // edge then passes only with a zero debounce.
  assign rise_hit     = (fall_hit ? (cfg.debounce_ms == '0) : deb_ok) && rise_lvl;
  // Signed compare v < low - margin, done without wrap as v + margin < low.
  assign below_margin = ({1'b0, sample_q} + MarginQ15) < {1'b0, cfg.low_thr};

  always_comb begin
    state_d       = state_q;
    prev_sample_d = prev_sample_q;
    last_edge_d   = last_edge_q;
    seq_start_d   = seq_start_q;
    unlock_time_d = unlock_time_q;
    count_d       = count_q;
    unlocked_d    = unlocked_q;
    event_d       = tcu_pkg::EvNone;

    unique case (mode_q)
      tcu_pkg::ModeSample: begin
        prev_sample_d = sample_q;
        if (timed_out) begin
          state_d     = ST_IDLE;
          count_d     = '0;
          seq_start_d = now_q;
          event_d     = tcu_pkg::EvTimeout;
        end else begin
          unique case (state_q)
            ST_IDLE: begin
              if (below_low) begin
                state_d     = ST_ARMED;
                count_d     = '0;
                seq_start_d = now_q;
              end
            end
            ST_ARMED: begin
              if (deb_ok && rise_lvl) begin
                state_d     = ST_CROSS1;
                last_edge_d = now_q;
                count_d     = 4'd1;
                seq_start_d = now_q;
                event_d     = tcu_pkg::EvRise;
              end
            end
            ST_CROSS1, ST_CROSS2: begin
              if (fall_hit || rise_hit) begin
                last_edge_d = now_q;
              end
              if (rise_hit) begin
                event_d = tcu_pkg::EvRise;
                if (state_q == ST_CROSS1) begin
                  state_d = ST_CROSS2;
                  count_d = 4'd2;
                end else begin
                  state_d = ST_CROSS3;
                  count_d = 4'd3;
                end
              end else if (fall_hit) begin
                event_d = tcu_pkg::EvFall;
              end
            end
            ST_CROSS3: begin
              if (count_q >= cfg.passes) begin
                state_d       = ST_UNLOCKED;
                unlocked_d    = 1'b1;
                unlock_time_d = now_q;
                event_d       = tcu_pkg::EvUnlock;
              end
            end
            ST_UNLOCKED: begin
              if (below_margin) begin
                state_d = ST_LOCKED;
              end
            end
            ST_LOCKED: begin
              if (lock_over) begin
                state_d     = ST_IDLE;
                unlocked_d  = 1'b0;
                count_d     = '0;
                seq_start_d = now_q;
                event_d     = tcu_pkg::EvLockEnd;
              end
            end
            default: ;
          endcase
        end
      end
      tcu_pkg::ModeUnlock: begin
        state_d       = ST_UNLOCKED;
        unlocked_d    = 1'b1;
        unlock_time_d = now_q;
        count_d       = cfg.passes;
        event_d       = tcu_pkg::EvUnlock;
      end
      tcu_pkg::ModeLock: begin
        state_d    = ST_LOCKED;
        unlocked_d = 1'b0;
      end
      tcu_pkg::ModeReset: begin
        state_d       = ST_IDLE;
        count_d       = '0;
        unlocked_d    = 1'b0;
        unlock_time_d = '0;
        seq_start_d   = now_q;
        prev_sample_d = '0;
        last_edge_d   = '0;
      end
      default: ;
    endcase

    // A sample reports against the sequence start it found; the other modes
    // report against the start left after the action.
    dur_d        = (mode_q == tcu_pkg::ModeSample) ? dur_pre : (now_q - seq_start_d);
    unlock_dur_d = unlocked_d ? (now_q - unlock_time_d) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      state_q       <= ST_IDLE;
      prev_sample_q <= '0;
      last_edge_q   <= '0;
      seq_start_q   <= '0;
      unlock_time_q <= '0;
      count_q       <= '0;
      unlocked_q    <= 1'b0;
      event_q       <= tcu_pkg::EvNone;
      dur_q         <= '0;
      unlock_dur_q  <= '0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q   <= 1'b1;
        state_q       <= state_d;
        prev_sample_q <= prev_sample_d;
        last_edge_q   <= last_edge_d;
        seq_start_q   <= seq_start_d;
        unlock_time_q <= unlock_time_d;
        count_q       <= count_d;
        unlocked_q    <= unlocked_d;
        event_q       <= event_d;
        dur_q         <= dur_d;
        unlock_dur_q  <= unlock_dur_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The result fields reflect the machine right after the item, which is
  // exactly what the state registers hold once the pass has run.
  assign out_valid_o          = out_valid_q;
  assign event_res_o          = event_q;
  assign machine_state_o      = state_q;
  assign crossing_total_o     = count_q;
  assign unlock_granted_o     = unlocked_q;
  assign state_duration_ms_o  = dur_q;
  assign unlock_duration_ms_o = unlock_dur_q;

`ifndef SYNTH
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a held result");

  a_unlocked_state_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (machine_state_o == ST_UNLOCKED)) |-> unlock_granted_o)
    else $error("unlocked state without the unlocked flag");

  a_idle_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ((machine_state_o == ST_IDLE) || (machine_state_o == ST_ARMED)))
      |-> (crossing_total_o == '0))
    else $error("crossing count not cleared in idle or armed");

  a_locked_dur_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !unlock_granted_o) |-> (unlock_duration_ms_o == '0))
    else $error("unlock duration reported while not unlocked");
`endif

endmodule

[verif/tb_threshold_crossing_unlock_fsm.sv]
module tb_threshold_crossing_unlock_fsm;
  timeunit 1ns;
  timeprecision 1ps;

  // Machine states as the block encodes them.
  typedef enum logic [2:0] {
    StIdle, StArmed, StCross1, StCross2, StCross3, StUnlocked, StLockedOut
  } fsm_state_e;

  // One result beat, field for field.
  typedef struct packed {
    logic [2:0]  event_code;
    logic [2:0]  state_code;
    logic [3:0]  crossings;
    logic        granted;
    logic [31:0] held_ms;
    logic [31:0] granted_ms;
  } unlock_status_t;

  // One row of the directed script. Rows with typed set carry a result that
  // is obvious from the rules; the others take the predicted result.
  typedef struct packed {
    logic [1:0]     mode;
    logic [15:0]    sample;
    logic [31:0]    now;
    logic           typed;
    unlock_status_t want;
  } script_row_t;

  // A 0.1 drop in Q1.15, rounded to nearest.
  localparam int MarginQ15    = 3277;
  localparam int RandomItems  = 1950;
  localparam int Phases       = 10;
  // Slack after the last result before the block counts as idle.
  localparam int SettleCycles = 6;
  localparam int PrintLimit   = 40;
  localparam unlock_status_t Untyped = '0;

  logic                         clk_i          = 1'b0;
  logic                         rst_ni         = 1'b0;
  logic                         cfg_we_i       = 1'b0;
  logic [tcu_pkg::CfgIdxW-1:0]  cfg_index_i    = '0;
  logic [tcu_pkg::CfgDataW-1:0] cfg_wdata_i    = '0;
  logic                         in_valid_i     = 1'b0;
  logic                         in_ready_o;
  logic [1:0]                   mode_i         = '0;
  logic [15:0]                  sample_value_i = '0;
  logic [31:0]                  now_ms_i       = '0;
  logic                         out_valid_o;
  logic                         out_ready_i    = 1'b0;
  logic [2:0]                   event_res_o;
  logic [2:0]                   machine_state_o;
  logic [3:0]                   crossing_total_o;
  logic                         unlock_granted_o;
  logic [31:0]                  state_duration_ms_o;
  logic [31:0]                  unlock_duration_ms_o;

  threshold_crossing_unlock_fsm dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_o,
    .mode_i,
    .sample_value_i,
    .now_ms_i,
    .out_valid_o,
    .out_ready_i,
    .event_res_o,
    .machine_state_o,
    .crossing_total_o,
    .unlock_granted_o,
    .state_duration_ms_o,
    .unlock_duration_ms_o
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Shadow of the configuration registers and of the machine, kept in step
  // with every accepted input beat.
  tcu_pkg::cfg_t cfg_shadow;
  logic [2:0]    m_state;
  logic [15:0]   prev_sample;
  logic [31:0]   last_edge_ms;
  logic [31:0]   seq_start_ms;
  logic [31:0]   unlock_at_ms;
  logic [3:0]    cross_count;
  logic          unlocked;

  unlock_status_t status_due_q [$];
  int unsigned    mismatches = 0;

  // Sender idling: bursts of random length, a gap after a burst with this
  // chance in percent. Receiver stalls follow a rotating 16-bit pattern.
  int unsigned gap_pct     = 0;
  int unsigned burst_left  = 0;
  logic [15:0] ready_pattern = 16'hFFFF;
  logic [3:0]  ready_phase   = '0;

  // The idle and armed states open a new sequence: the count is cleared and
  // the sequence start moves to now. Other states keep both.
  function automatic void enter_state(logic [2:0] s, logic [31:0] now);
    m_state = s;
    if (s == StIdle || s == StArmed) begin
      cross_count  = '0;
      seq_start_ms = now;
    end
  endfunction

  // Debounced edge test against the last accepted edge. A hit takes the
  // debounce slot, which is why a falling edge in a step blocks a rising one
  // unless the debounce time is zero.
  function automatic bit crossed(bit upward, logic [15:0] v, logic [31:0] now);
    bit hit;
    if (now - last_edge_ms < cfg_shadow.debounce_ms) return 1'b0;
    hit = upward ? (prev_sample < cfg_shadow.high_thr && v >= cfg_shadow.high_thr)
                 : (prev_sample >= cfg_shadow.low_thr && v < cfg_shadow.low_thr);
    if (hit) last_edge_ms = now;
    return hit;
  endfunction

  // Applies one input beat to the shadow machine and returns the result beat
  // the block has to give for it.
  function automatic unlock_status_t advance_machine(logic [1:0] m, logic [15:0] v,
                                                     logic [31:0] now);
    unlock_status_t r;
    logic [31:0]    held;
    r = '0;
    r.event_code = tcu_pkg::EvNone;
    if (m == tcu_pkg::ModeSample) begin
      // For a sample the duration is measured against the start held before
      // the sample does anything.
      held = now - seq_start_ms;
      if ((m_state == StArmed || m_state == StCross1 || m_state == StCross2 ||
           m_state == StCross3) && held > cfg_shadow.seq_tmo_ms) begin
        enter_state(StIdle, now);
        r.event_code = tcu_pkg::EvTimeout;
      end else if (m_state == StLockedOut) begin
        // Lockout is timed from the unlock time, not from the fall.
        if (now - unlock_at_ms > cfg_shadow.lockout_ms) begin
          unlocked = 1'b0;
          enter_state(StIdle, now);
          r.event_code = tcu_pkg::EvLockEnd;
        end
      end else begin
        case (m_state)
          StIdle: begin
            if (v < cfg_shadow.low_thr) enter_state(StArmed, now);
          end
          StArmed: begin
            if (crossed(1'b1, v, now)) begin
              cross_count  = 4'd1;
              seq_start_ms = now;
              enter_state(StCross1, now);
              r.event_code = tcu_pkg::EvRise;
            end
          end
          StCross1, StCross2: begin
            if (crossed(1'b0, v, now)) r.event_code = tcu_pkg::EvFall;
            if (crossed(1'b1, v, now)) begin
              cross_count = (m_state == StCross1) ? 4'd2 : 4'd3;
              enter_state((m_state == StCross1) ? StCross2 : StCross3, now);
              r.event_code = tcu_pkg::EvRise;
            end
          end
          StCross3: begin
            // With more passes required than three the machine sits here
            // until the sequence times out.
            if (cross_count >= cfg_shadow.passes) begin
              unlocked     = 1'b1;
              unlock_at_ms = now;
              enter_state(StUnlocked, now);
              r.event_code = tcu_pkg::EvUnlock;
            end
          end
          StUnlocked: begin
            // Signed compare, so a low threshold under the margin never wraps.
            if (int'(v) < int'(cfg_shadow.low_thr) - MarginQ15)
              enter_state(StLockedOut, now);
          end
          default: begin
          end
        endcase
      end
      prev_sample = v;
    end else begin
      // Forced unlock and lock leave the previous sample alone; a reset clears it.
      case (m)
        tcu_pkg::ModeUnlock: begin
          unlocked     = 1'b1;
          unlock_at_ms = now;
          cross_count  = cfg_shadow.passes;
          enter_state(StUnlocked, now);
          r.event_code = tcu_pkg::EvUnlock;
        end
        tcu_pkg::ModeLock: begin
          unlocked = 1'b0;
          enter_state(StLockedOut, now);
        end
        default: begin
          m_state      = StIdle;
          cross_count  = '0;
          unlocked     = 1'b0;
          unlock_at_ms = '0;
          seq_start_ms = now;
          prev_sample  = '0;
          last_edge_ms = '0;
        end
      endcase
      held = now - seq_start_ms;
    end
    r.state_code = m_state;
    r.crossings  = cross_count;
    r.granted    = unlocked;
    r.held_ms    = held;
    r.granted_ms = unlocked ? now - unlock_at_ms : 32'd0;
    return r;
  endfunction

  function automatic logic [15:0] level_under(int x);
    if (x <= 0) return '0;
    return 16'($urandom_range(x - 1, 0));
  endfunction

  function automatic logic [15:0] level_over(int x);
    return 16'($urandom_range(65535, x));
  endfunction

  // Picks a sample that pushes the machine on from where it stands: below the
  // low level to arm, alternating over and under to count crossings, under
  // the margin to fall into lockout. A share of boundary values and noise is
  // mixed in.
  function automatic logic [15:0] pick_sample();
    int unsigned r;
    int          lo;
    int          hi;
    r  = $urandom_range(99, 0);
    lo = cfg_shadow.low_thr;
    hi = cfg_shadow.high_thr;
    if (r < 10) return 16'($urandom());
    if (r < 20) begin
      case ($urandom_range(5, 0))
        0:       return 16'(lo - 1);
        1:       return 16'(lo);
        2:       return 16'(hi);
        3:       return 16'(hi - 1);
        4:       return 16'(lo - MarginQ15);
        default: return 16'(lo - MarginQ15 - 1);
      endcase
    end
    case (m_state)
      StIdle:                      return level_under(lo);
      StUnlocked:                  return (r < 45) ? level_under(lo - MarginQ15)
                                                   : level_over(hi);
      StArmed, StCross1, StCross2: return (prev_sample >= hi) ? level_under(lo)
                                                              : level_over(hi);
      default:                     return 16'($urandom());
    endcase
  endfunction

  // Time step between beats. Most steps clear the debounce time; some fall
  // inside it, and some jump far enough to hit a timeout or end a lockout.
  function automatic logic [31:0] step_ms();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 12) return $urandom_range(cfg_shadow.debounce_ms, 0);
    if (r < 17) return $urandom();
    return cfg_shadow.debounce_ms + $urandom_range(250, 0);
  endfunction

  task automatic write_reg(input logic [tcu_pkg::CfgIdxW-1:0] idx,
                           input logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    // Each register keeps only the low bits of its own width.
    case (idx)
      tcu_pkg::RegHighThr:  cfg_shadow.high_thr    = data[15:0];
      tcu_pkg::RegLowThr:   cfg_shadow.low_thr     = data[15:0];
      tcu_pkg::RegPasses:   cfg_shadow.passes      = data[3:0];
      tcu_pkg::RegSeqTmo:   cfg_shadow.seq_tmo_ms  = data;
      tcu_pkg::RegLockout:  cfg_shadow.lockout_ms  = data;
      tcu_pkg::RegDebounce: cfg_shadow.debounce_ms = data;
      default: begin
      end
    endcase
  endtask

  // Writes all six registers. Half the time the bits above a narrow
  // register's width carry junk, which the block has to drop.
  task automatic load_settings(input logic [15:0] h, input logic [15:0] l,
                               input logic [3:0] p, input logic [31:0] tmo,
                               input logic [31:0] lock, input logic [31:0] dbc);
    logic [31:0] junk;
    junk = ($urandom_range(1, 0) == 1) ? 32'($urandom()) : '0;
    write_reg(tcu_pkg::RegHighThr, {junk[15:0], h});
    write_reg(tcu_pkg::RegLowThr, {junk[31:16], l});
    write_reg(tcu_pkg::RegPasses, {junk[27:0], p});
    write_reg(tcu_pkg::RegSeqTmo, tmo);
    write_reg(tcu_pkg::RegLockout, lock);
    write_reg(tcu_pkg::RegDebounce, dbc);
    cfg_we_i <= 1'b0;
  endtask

  // Offers one beat and waits for it to be taken. The expected result is
  // queued at the edge that takes the beat, which is well before the block
  // can answer it.
  task automatic send_beat(input logic [1:0] m, input logic [15:0] v,
                           input logic [31:0] now, input logic typed,
                           input unlock_status_t typed_want);
    unlock_status_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(16, 1);
      if ($urandom_range(99, 0) < gap_pct) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(6, 1)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i     <= 1'b1;
    mode_i         <= m;
    sample_value_i <= v;
    now_ms_i       <= now;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = advance_machine(m, v, now);
    status_due_q.push_back(typed ? typed_want : predicted);
  endtask

  // Waits until every expected result has come back, then lets the pipeline
  // run empty before anything else happens.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (status_due_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic void compare_field(string label, logic [31:0] want,
                                        logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= PrintLimit)
        $display("%0t ns: %s expected %0d, got %0d", $time, label, want, got);
    end
  endfunction

  // Result side: checks every result beat against the oldest expectation and
  // drives the stall pattern. Values are sampled as they stood before the
  // edge, since the inputs only change through nonblocking updates.
  always @(posedge clk_i) begin : result_side
    unlock_status_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (status_due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= PrintLimit)
          $display("%0t ns: result beat with nothing expected, expected none, got %0d",
                   $time, event_res_o);
      end else begin
        want = status_due_q.pop_front();
        compare_field("event_res", 32'(want.event_code), 32'(event_res_o));
        compare_field("machine_state", 32'(want.state_code), 32'(machine_state_o));
        compare_field("crossing_total", 32'(want.crossings), 32'(crossing_total_o));
        compare_field("unlock_granted", 32'(want.granted), 32'(unlock_granted_o));
        compare_field("state_duration_ms", want.held_ms, state_duration_ms_o);
        compare_field("unlock_duration_ms", want.granted_ms, unlock_duration_ms_o);
      end
    end
    out_ready_i <= ready_pattern[ready_phase];
    ready_phase <= ready_phase + 4'd1;
  end

  // Directed script, run with the reset settings. It walks a full sequence
  // from arming through three crossings to unlock, the exact margin bound,
  // the lockout bound, the forced modes, a clear, time wrapping past zero
  // and the timeout bound.
  script_row_t script [24] = '{
    // Clear right after reset.
    '{tcu_pkg::ModeReset,  16'hFFFF, 32'd0,          1'b1,
      '{tcu_pkg::EvNone, StIdle, 4'd0, 1'b0, 32'd0, 32'd0}},
    // Arming sample.
    '{tcu_pkg::ModeSample, 16'h0000, 32'd10,         1'b1,
      '{tcu_pkg::EvNone, StArmed, 4'd0, 1'b0, 32'd10, 32'd0}},
    '{tcu_pkg::ModeSample, 16'hFFFF, 32'd200,        1'b0, Untyped},
    // Inside the debounce time.
    '{tcu_pkg::ModeSample, 16'h0000, 32'd250,        1'b0, Untyped},
    '{tcu_pkg::ModeSample, 16'd40000, 32'd400,       1'b0, Untyped},
    '{tcu_pkg::ModeSample, 16'h0000, 32'd600,        1'b0, Untyped},
    '{tcu_pkg::ModeSample, 16'd32768, 32'd800,       1'b0, Untyped},
    '{tcu_pkg::ModeSample, 16'd100,  32'd900,        1'b0, Untyped},
    // Exactly at the margin, then one below it.
    '{tcu_pkg::ModeSample, 16'd23593, 32'd1000,      1'b0, Untyped},
    '{tcu_pkg::ModeSample, 16'd23592, 32'd1100,      1'b0, Untyped},
    // Lockout at its bound, then one past it.
    '{tcu_pkg::ModeSample, 16'h0000, 32'd5900,       1'b0, Untyped},
    '{tcu_pkg::ModeSample, 16'h0000, 32'd5901,       1'b0, Untyped},
    '{tcu_pkg::ModeUnlock, 16'h0000, 32'd6000,       1'b0, Untyped},
    '{tcu_pkg::ModeLock,   16'hFFFF, 32'd7000,       1'b0, Untyped},
    '{tcu_pkg::ModeSample, 16'hFFFF, 32'hFFFF_FFFF,  1'b0, Untyped},
    '{tcu_pkg::ModeReset,  16'hFFFF, 32'hFFFF_FFFF,  1'b1,
      '{tcu_pkg::EvNone, StIdle, 4'd0, 1'b0, 32'd0, 32'd0}},
    // Time wraps past zero.
    '{tcu_pkg::ModeSample, 16'h0000, 32'd0,          1'b1,
      '{tcu_pkg::EvNone, StArmed, 4'd0, 1'b0, 32'd1, 32'd0}},
    // Sequence timeout at its bound, then one past it.
    '{tcu_pkg::ModeSample, 16'h0000, 32'd10000,      1'b0, Untyped},
    '{tcu_pkg::ModeSample, 16'h0000, 32'd10001,      1'b1,
      '{tcu_pkg::EvTimeout, StIdle, 4'd0, 1'b0, 32'd10001, 32'd0}},
    '{tcu_pkg::ModeSample, 16'd30000, 32'd10002,     1'b0, Untyped},
    '{tcu_pkg::ModeUnlock, 16'h1234, 32'hFFFF_FFFF,  1'b0, Untyped},
    '{tcu_pkg::ModeSample, 16'd32768, 32'd4998,      1'b0, Untyped},
    '{tcu_pkg::ModeLock,   16'h0000, 32'd5000,       1'b0, Untyped},
    '{tcu_pkg::ModeSample, 16'h0000, 32'd5000,       1'b0, Untyped}
  };

  initial begin : stimulus
    logic [31:0] clock_ms;
    logic [1:0]  m;
    logic [15:0] v;
    logic [15:0] h;
    logic [15:0] l;
    int unsigned r;

    cfg_shadow   = '{tcu_pkg::HighThrRst, tcu_pkg::LowThrRst, tcu_pkg::PassesRst,
                     tcu_pkg::SeqTmoRst, tcu_pkg::LockoutRst, tcu_pkg::DebounceRst};
    m_state      = StIdle;
    prev_sample  = '0;
    last_edge_ms = '0;
    seq_start_ms = '0;
    unlock_at_ms = '0;
    cross_count  = '0;
    unlocked     = 1'b0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    gap_pct       = 25;
    ready_pattern <= 16'hB5D3;
    foreach (script[i])
      send_beat(script[i].mode, script[i].sample, script[i].now, script[i].typed,
                script[i].want);
    drain();

    // Random phases. The first restores the reset values, the second zeroes all
    // but a maximal debounce, the third is the reverse with thresholds at 32768,
    // the rest pick moderate settings where the sequence can mostly be walked.
    for (int p = 0; p < Phases; p++) begin
      gap_pct = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(60, 5);
      ready_pattern <= ($urandom_range(3, 0) == 0) ? 16'hFFFF
                                                   : (16'($urandom()) | 16'h0001);
      case (p)
        0: load_settings(tcu_pkg::HighThrRst, tcu_pkg::LowThrRst, tcu_pkg::PassesRst,
                         tcu_pkg::SeqTmoRst, tcu_pkg::LockoutRst,
                         tcu_pkg::DebounceRst);
        1: load_settings(16'd0, 16'd0, 4'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
        2: load_settings(16'd32768, 16'd32768, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'd0);
        default: begin
          h = 16'($urandom_range(32768, 16384));
          // Now and then the low level lands anywhere, above the high one too.
          l = ($urandom_range(4, 0) == 0) ? 16'($urandom_range(32768, 0))
                                          : 16'($urandom_range(h - 1, 4096));
          load_settings(h, l,
                        ($urandom_range(3, 0) == 0) ? 4'($urandom_range(15, 0))
                                                    : 4'($urandom_range(4, 0)),
                        $urandom_range(20000, 1500), $urandom_range(6000, 300),
                        ($urandom_range(3, 0) == 0) ? 32'd0 : $urandom_range(300, 1));
        end
      endcase

      clock_ms = $urandom();
      for (int k = 0; k < RandomItems / Phases; k++) begin
        r = $urandom_range(99, 0);
        if (r < 4)       m = tcu_pkg::ModeUnlock;
        else if (r < 8)  m = tcu_pkg::ModeLock;
        else if (r < 12) m = tcu_pkg::ModeReset;
        else             m = tcu_pkg::ModeSample;
        clock_ms += step_ms();
        if ($urandom_range(99, 0) < 3) clock_ms = $urandom();
        v = (m == tcu_pkg::ModeSample) ? pick_sample() : 16'($urandom());
        send_beat(m, v, clock_ms, 1'b0, Untyped);
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // A correct run needs well under a tenth of this.
  initial begin : watchdog
    #5_000_000;
    $display("%0t ns: run did not finish, %0d results still expected", $time,
             status_due_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
